[hdl/crce_pkg.sv]
// Shared types, constants and CRC step functions for the CRC engine.
`default_nettype none

package crce_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned CrcW      = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CrcW-1:0] RstPoly  = 32'h04C1_1DB7;
  localparam logic [CrcW-1:0] RstStart = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] RstXor   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    WSEL_8      = 2'd0,
    WSEL_16     = 2'd1,
    WSEL_32     = 2'd2,
    WSEL_32_ALT = 2'd3
  } wsel_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_WIDTH   = 3'd0,
    REG_POLY    = 3'd1,
    REG_START   = 3'd2,
    REG_XOR     = 3'd3,
    REG_REFLECT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    wsel_e           wsel;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] start;
    logic [CrcW-1:0] xorv;
    logic            reflect;
  } cfg_t;

  // One queued beat: byte, reflected if enabled, plus message position marks.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic             first;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [CrcW-1:0] width_mask(input wsel_e wsel);
    logic [CrcW-1:0] m;
    begin
      unique case (wsel)
        WSEL_8:  m = 32'h0000_00FF;
        WSEL_16: m = 32'h0000_FFFF;
        default: m = 32'hFFFF_FFFF;
      endcase
      return m;
    end
  endfunction

  function automatic logic top_bit(input logic [CrcW-1:0] v, input wsel_e wsel);
    logic b;
    begin
      unique case (wsel)
        WSEL_8:  b = v[7];
        WSEL_16: b = v[15];
        default: b = v[31];
      endcase
      return b;
    end
  endfunction

  function automatic logic [DataW-1:0] reverse8(input logic [DataW-1:0] v);
    logic [DataW-1:0] r;
    begin
      for (int i = 0; i < DataW; i++) r[i] = v[DataW-1-i];
      return r;
    end
  endfunction

  // XOR the byte into the top of the register, then eight MSB-first steps.
  function automatic logic [CrcW-1:0] crc_byte_step(input logic [CrcW-1:0] crc_in,
                                                    input logic [DataW-1:0] data,
                                                    input cfg_t cfg);
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] c;
    begin
      mask = width_mask(cfg.wsel);
      c    = crc_in & mask;
      unique case (cfg.wsel)
        WSEL_8:  c = c ^ {24'd0, data};
        WSEL_16: c = c ^ {16'd0, data, 8'd0};
        default: c = c ^ {data, 24'd0};
      endcase
      for (int i = 0; i < 8; i++) begin
        if (top_bit(c, cfg.wsel)) c = ({c[CrcW-2:0], 1'b0} ^ cfg.poly) & mask;
        else                      c = {c[CrcW-2:0], 1'b0} & mask;
      end
      return c;
    end
  endfunction

  // Mirror over the selected width if reflect is set, then apply the output XOR.
  function automatic logic [CrcW-1:0] crc_finish(input logic [CrcW-1:0] crc,
                                                 input cfg_t cfg);
    logic [CrcW-1:0] rev;
    logic [CrcW-1:0] c;
    begin
      for (int i = 0; i < CrcW; i++) rev[i] = crc[CrcW-1-i];
      unique case (cfg.wsel)
        WSEL_8:  rev = {24'd0, rev[31:24]};
        WSEL_16: rev = {16'd0, rev[31:16]};
        default: rev = rev;
      endcase
      c = cfg.reflect ? rev : crc;
      return (c ^ cfg.xorv) & width_mask(cfg.wsel);
    end
  endfunction

endpackage

`default_nettype wire

[hdl/configurable_crc_engine_unit.sv]
// Top level of the configurable 8/16/32-bit CRC engine.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------
//   input    | in        | in_valid_i / in_stall_o | data_byte_i, last_byte_i
//   output   | out       | out_valid_o/out_stall_i | crc_result_o
//   config   | in        | psel/penable/pready     | paddr, pwdata, prdata
//
// One byte per cycle without output stalls; the eight-step XOR shift unit in
// the datapath takes one beat each cycle. Results go via queue and res_q.
// Reset loads the register defaults; there is no clearing pass.
// Input stalls only while the queue is full; the queue absorbs output stalls.
`default_nettype none

module configurable_crc_engine_unit
  import crce_pkg::*;
#(
  parameter int unsigned FifoDepthP = FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [CrcW-1:0]  crc_result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [CrcW-1:0]  pwdata,
  output logic      [CrcW-1:0]  prdata,
  output logic                  pready
);

  cfg_t       cfg;
  fifo_stat_t fifo_stat;
  item_t      push_item, pop_item;
  logic       push, pop;

  crce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cfg_i       (cfg),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  crce_fifo #(
    .Depth (FifoDepthP)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (fifo_stat)
  );

  crce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fifo_stat_i  (fifo_stat),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .crc_result_o (crc_result_o)
  );

`ifndef SYNTHESIS
  a_fifo_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.empty && fifo_stat.full))
    else $error("queue reports empty and full together");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> in_stall_o)
    else $error("input not stalled while queue full");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop && pop_item.last))
    else $error("result appeared without a last beat");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("datapath advanced on an empty queue");
`endif

endmodule

`default_nettype wire

[hdl/crce_cfg.sv]
// APB register file holding the CRC engine settings.
`default_nettype none

module crce_cfg
  import crce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [CrcW-1:0]  pwdata,
  output logic      [CrcW-1:0]  prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t            cfg_q, cfg_d;
  logic            wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:   cfg_d.wsel    = wsel_e'(pwdata[1:0]);
        REG_POLY:    cfg_d.poly    = pwdata;
        REG_START:   cfg_d.start   = pwdata;
        REG_XOR:     cfg_d.xorv    = pwdata;
        REG_REFLECT: cfg_d.reflect = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:   prdata = {30'd0, cfg_q.wsel};
      REG_POLY:    prdata = cfg_q.poly;
      REG_START:   prdata = cfg_q.start;
      REG_XOR:     prdata = cfg_q.xorv;
      REG_REFLECT: prdata = {31'd0, cfg_q.reflect};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wsel    <= WSEL_32;
      cfg_q.poly    <= RstPoly;
      cfg_q.start   <= RstStart;
      cfg_q.xorv    <= RstXor;
      cfg_q.reflect <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/crce_front.sv]
// Input side: accepts beats, tracks message start and reflects the byte.
`default_nettype none

module crce_front
  import crce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  input  wire cfg_t             cfg_i,
  input  wire fifo_stat_t       fifo_stat_i,
  output logic                  push_o,
  output item_t                 item_o
);

  logic open_q, open_d;

  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  assign item_o.data  = cfg_i.reflect ? reverse8(data_byte_i) : data_byte_i;
  assign item_o.last  = last_byte_i;
  assign item_o.first = !open_q;

  // Message stays open until its last beat goes through.
  assign open_d = push_o ? !last_byte_i : open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

`default_nettype wire

[hdl/crce_fifo.sv]
// Short queue between the input side and the CRC datapath.
`default_nettype none

module crce_fifo
  import crce_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire item_t      item_i,
  input  wire logic       pop_i,
  output item_t           item_o,
  output fifo_stat_t      stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[hdl/crce_back.sv]
// CRC datapath: one byte per unstalled cycle into the running CRC, result reg.
`default_nettype none

module crce_back
  import crce_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire fifo_stat_t      fifo_stat_i,
  input  wire item_t           item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [CrcW-1:0] crc_result_o
);

  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] res_q, res_d;
  logic            vld_q, vld_d;
  logic [CrcW-1:0] crc_in, crc_next;

  // Advance when the queue holds a beat and the result slot is free or drains.
  assign pop_o    = !fifo_stat_i.empty && (!vld_q || !out_stall_i);
  assign crc_in   = item_i.first ? cfg_i.start : crc_q;
  assign crc_next = crc_byte_step(crc_in, item_i.data, cfg_i);

  always_comb begin
    crc_d = crc_q;
    res_d = res_q;
    vld_d = vld_q && out_stall_i;
    if (pop_o) begin
      crc_d = crc_next;
      vld_d = item_i.last;
      if (item_i.last) res_d = crc_finish(crc_next, cfg_i);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o  = vld_q;
  assign crc_result_o = res_q;

endmodule

`default_nettype wire

[bench/configurable_crc_engine_unit_tb.sv]
// Self-checking bench for the CRC engine: byte stream in, final CRC out, APB setup.
`default_nettype none

module configurable_crc_engine_unit_tb;
  import crce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandPhases = 14;
  localparam int unsigned BytesPerPhase = 46;
  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic [DataW-1:0] data;
    logic             last;
  } msg_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid_r = 1'b0;
  logic [DataW-1:0] in_data_r = '0;
  logic             in_last_r = 1'b0;
  logic             out_stall_r = 1'b0;
  logic             psel_r = 1'b0;
  logic             penable_r = 1'b0;
  logic             pwrite_r = 1'b0;
  logic [AddrW-1:0] paddr_r = '0;
  logic [CrcW-1:0]  pwdata_r = '0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic [CrcW-1:0]  crc_result_o;
  logic [CrcW-1:0]  prdata;
  logic             pready;

  // Shadow of the configuration registers and of the running CRC state.
  wsel_e           cfg_wsel = WSEL_32;
  logic [CrcW-1:0] cfg_poly = RstPoly;
  logic [CrcW-1:0] cfg_start = RstStart;
  logic [CrcW-1:0] cfg_xor = RstXor;
  logic            cfg_reflect = 1'b1;
  logic [CrcW-1:0] crc_reg = RstStart;
  bit              msg_open = 1'b0;

  msg_beat_t       byte_q[$];
  logic [CrcW-1:0] crc_expect_q[$];
  bit              beat_taken = 1'b0;
  int unsigned     cycle_cnt = 0;
  int unsigned     err_cnt = 0;
  bit              calm;

  configurable_crc_engine_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_stall_o  (in_stall_o),
    .data_byte_i (in_data_r),
    .last_byte_i (in_last_r),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_r),
    .crc_result_o(crc_result_o),
    .psel        (psel_r),
    .penable     (penable_r),
    .pwrite      (pwrite_r),
    .paddr       (paddr_r),
    .pwdata      (pwdata_r),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // No idling on either side inside this window.
  assign calm = (cycle_cnt >= 600) && (cycle_cnt < 1000);

  function automatic int unsigned crc_width(input wsel_e wsel);
    unique case (wsel)
      WSEL_8:  return 8;
      WSEL_16: return 16;
      default: return 32;
    endcase
  endfunction

  function automatic logic [CrcW-1:0] mirror_bits(input logic [CrcW-1:0] v,
                                                  input int unsigned w);
    logic [CrcW-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < w; i++) begin
      r = {r[CrcW-2:0], v[0]};
      v = v >> 1;
    end
    return r;
  endfunction

  // Absorb one byte into the running CRC; returns 1 with the final CRC on a last byte.
  function automatic bit crc_absorb(input logic [DataW-1:0] b_in, input logic last,
                                    output logic [CrcW-1:0] crc_out);
    int unsigned     w;
    logic [CrcW-1:0] mask;
    logic [CrcW-1:0] top;
    logic [CrcW-1:0] c;
    logic [CrcW-1:0] b;
    w = crc_width(cfg_wsel);
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
    top = 32'd1 << (w - 1);
    b = {24'd0, b_in};
    crc_out = '0;
    if (!msg_open) begin
      crc_reg = cfg_start;
      msg_open = 1'b1;
    end
    c = crc_reg & mask;
    if (cfg_reflect) b = mirror_bits(b, 8);
    c = c ^ (b << (w - 8));
    for (int i = 0; i < 8; i++) begin
      if ((c & top) != 0) c = ((c << 1) ^ cfg_poly) & mask;
      else c = (c << 1) & mask;
    end
    crc_reg = c;
    if (!last) return 1'b0;
    if (cfg_reflect) c = mirror_bits(c, w);
    crc_out = (c ^ cfg_xor) & mask;
    crc_reg = cfg_start & mask;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  task automatic reg_write(input reg_idx_e idx, input logic [CrcW-1:0] val);
    @(negedge clk_i);
    psel_r <= 1'b1;
    penable_r <= 1'b0;
    pwrite_r <= 1'b1;
    paddr_r <= {idx, 2'b00};
    pwdata_r <= val;
    @(negedge clk_i);
    penable_r <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel_r <= 1'b0;
    penable_r <= 1'b0;
    pwrite_r <= 1'b0;
    unique case (idx)
      REG_WIDTH:   cfg_wsel = wsel_e'(val[1:0]);
      REG_POLY:    cfg_poly = val;
      REG_START:   cfg_start = val;
      REG_XOR:     cfg_xor = val;
      REG_REFLECT: cfg_reflect = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input wsel_e wsel, input logic [CrcW-1:0] poly,
                            input logic [CrcW-1:0] start, input logic [CrcW-1:0] xorv,
                            input logic reflect);
    reg_write(REG_WIDTH, {30'd0, wsel});
    reg_write(REG_POLY, poly);
    reg_write(REG_START, start);
    reg_write(REG_XOR, xorv);
    reg_write(REG_REFLECT, {31'd0, reflect});
  endtask

  function automatic logic [CrcW-1:0] pick_word(input logic [CrcW-1:0] usual);
    unique case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return usual;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_beat(input logic [DataW-1:0] data, input logic last);
    msg_beat_t bt;
    bt.data = data;
    bt.last = last;
    byte_q = {byte_q, bt};
  endtask

  task automatic push_message(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++)
      push_beat(DataW'($urandom_range(0, 255)), close && (i == len - 1));
  endtask

  // Wait until every queued beat is taken and every CRC has come back.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid_r || crc_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic note_error(input string what, input logic [CrcW-1:0] exp_v,
                            input logic [CrcW-1:0] act_v);
    if (err_cnt < ReportMax)
      $display("mismatch (%s) at cycle %0d: expected %08h, got %08h",
               what, cycle_cnt, exp_v, act_v);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Input side: predict on each accepted beat.
  always @(posedge clk_i) begin : in_mon
    logic [CrcW-1:0] crc_v;
    beat_taken <= rst_ni && in_valid_r && !in_stall_o;
    if (rst_ni && in_valid_r && !in_stall_o) begin
      if (crc_absorb(in_data_r, in_last_r, crc_v)) crc_expect_q = {crc_expect_q, crc_v};
    end
  end

  // Output side: compare each accepted CRC with the oldest prediction.
  always @(posedge clk_i) begin : out_mon
    logic [CrcW-1:0] exp_v;
    if (rst_ni && out_valid_o && !out_stall_r) begin
      if (crc_expect_q.size() == 0) begin
        note_error("unexpected result", '0, crc_result_o);
      end else begin
        exp_v = crc_expect_q.pop_front();
        if (crc_result_o !== exp_v) note_error("crc_result", exp_v, crc_result_o);
      end
    end
  end

  always @(negedge clk_i) begin : drive
    bit        gap;
    msg_beat_t nxt;
    gap = !calm && ($urandom_range(0, 99) < 18);
    if (!in_valid_r || beat_taken) begin
      if (rst_ni && byte_q.size() != 0 && !gap) begin
        nxt = byte_q.pop_front();
        in_valid_r <= 1'b1;
        in_data_r <= nxt.data;
        in_last_r <= nxt.last;
      end else begin
        in_valid_r <= 1'b0;
      end
    end
    out_stall_r <= !calm && ($urandom_range(0, 99) < 18);
  end

  initial begin
    int unsigned fill;
    int unsigned len;
    string       check_str;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: the standard check string.
    check_str = "123456789";
    for (int i = 0; i < check_str.len(); i++)
      push_beat(check_str[i], i == check_str.len() - 1);
    drain();

    // Narrow CRC, no reflection, zero start and XOR: extreme bytes.
    set_config(WSEL_8, 32'h07, '0, '0, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    drain();

    // Leave a 16-bit message open, then widen mid-message.
    set_config(WSEL_16, 32'h1021, 32'hFFFF, '0, 1'b0);
    push_beat(8'h31, 1'b0);
    push_beat(8'h32, 1'b0);
    push_beat(8'h33, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b0);
    drain();
    set_config(WSEL_32_ALT, '1, '0, '1, 1'b1);
    push_beat(8'hA5, 1'b1);
    drain();

    // Zero polynomial with reflection on single-bit bytes.
    set_config(WSEL_8, '0, '1, 32'h5A, 1'b1);
    push_beat(8'h80, 1'b1);
    push_beat(8'h01, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      set_config(wsel_e'($urandom_range(0, 3)), pick_word(RstPoly), pick_word(RstStart),
                 pick_word(RstXor), 1'($urandom_range(0, 1)));
      fill = 0;
      while (fill < BytesPerPhase) begin
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        push_message(len, 1'b1);
        fill += len;
      end
      // Sometimes carry an open message over the next configuration change.
      if ($urandom_range(0, 3) == 0) push_message($urandom_range(1, 3), 1'b0);
      drain();
    end

    drain();
    err_cnt += crc_expect_q.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
